[rtl/core/multi_step_majority_decoder_15_5_assert.svh]
// ---------------------------------------------------------------------------
// multi_step_majority_decoder_15_5 assertion macros
// Shared concurrent assertion forms for the majority-logic decoder.
// ---------------------------------------------------------------------------
`ifndef MULTI_STEP_MAJORITY_DECODER_15_5_ASSERT_SVH
`define MULTI_STEP_MAJORITY_DECODER_15_5_ASSERT_SVH

// property checked outside reset
`define MSMD_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("msmd assertion failed");

// condition that must hold in the cycle after reset is seen
`define MSMD_ASSERT_RESET(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) (rst) |=> (expr)) \
    else $error("msmd reset assertion failed");

`endif

[rtl/core/msmd_pkg.sv]
// ---------------------------------------------------------------------------
// msmd_pkg
// Types, check-sum tables and the round function of the (15,5) decoder.
// ---------------------------------------------------------------------------
package msmd_pkg;

  localparam int WORD_W     = 15;
  localparam int NUM_ROUNDS = 15;
  localparam int TOP_POS    = WORD_W - 1;
  localparam int NUM_GROUPS = 6;
  localparam int NUM_SUMS   = 6;
  localparam int SUM_TERMS  = 4;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [3:0]        pos_t;

  // code positions of each four-input check sum, six groups of six
  localparam pos_t CHECK_POS [NUM_GROUPS][NUM_SUMS][SUM_TERMS] = '{
    '{ '{4'd4, 4'd10, 4'd13, 4'd14}, '{4'd7, 4'd12, 4'd13, 4'd14},
       '{4'd9, 4'd11, 4'd13, 4'd14}, '{4'd0, 4'd8,  4'd13, 4'd14},
       '{4'd1, 4'd5,  4'd13, 4'd14}, '{4'd3, 4'd6,  4'd13, 4'd14} },
    '{ '{4'd0, 4'd10, 4'd12, 4'd14}, '{4'd3, 4'd11, 4'd12, 4'd14},
       '{4'd7, 4'd13, 4'd12, 4'd14}, '{4'd1, 4'd2,  4'd12, 4'd14},
       '{4'd4, 4'd8,  4'd12, 4'd14}, '{4'd6, 4'd9,  4'd12, 4'd14} },
    '{ '{4'd3, 4'd12, 4'd11, 4'd14}, '{4'd9, 4'd13, 4'd11, 4'd14},
       '{4'd0, 4'd5,  4'd11, 4'd14}, '{4'd1, 4'd8,  4'd11, 4'd14},
       '{4'd2, 4'd4,  4'd11, 4'd14}, '{4'd6, 4'd7,  4'd11, 4'd14} },
    '{ '{4'd0, 4'd12, 4'd10, 4'd14}, '{4'd4, 4'd13, 4'd10, 4'd14},
       '{4'd1, 4'd6,  4'd10, 4'd14}, '{4'd3, 4'd5,  4'd10, 4'd14},
       '{4'd7, 4'd8,  4'd10, 4'd14}, '{4'd2, 4'd9,  4'd10, 4'd14} },
    '{ '{4'd0, 4'd11, 4'd5,  4'd14}, '{4'd1, 4'd13, 4'd5,  4'd14},
       '{4'd3, 4'd10, 4'd5,  4'd14}, '{4'd4, 4'd6,  4'd5,  4'd14},
       '{4'd2, 4'd7,  4'd5,  4'd14}, '{4'd8, 4'd9,  4'd5,  4'd14} },
    '{ '{4'd1, 4'd12, 4'd2,  4'd14}, '{4'd4, 4'd11, 4'd2,  4'd14},
       '{4'd0, 4'd6,  4'd2,  4'd14}, '{4'd3, 4'd8,  4'd2,  4'd14},
       '{4'd5, 4'd7,  4'd2,  4'd14}, '{4'd9, 4'd10, 4'd2,  4'd14} }
  };

  // six-input majority gate, a 3-3 tie gives 0
  function automatic logic vote_of_six(logic [5:0] bits);
    logic [2:0] ones;
    ones = 3'd0;
    for (int i = 0; i < 6; i++) begin
      ones = ones + {2'b00, bits[i]};
    end
    return (ones > 3'd3);
  endfunction

  // one decoding round: vote, correct the top position, rotate up by one
  function automatic word_t decode_round(word_t w);
    logic [NUM_SUMS-1:0]   sums;
    logic [NUM_GROUPS-1:0] groups;
    word_t                 f;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      for (int s = 0; s < NUM_SUMS; s++) begin
        sums[s] = w[CHECK_POS[g][s][0]] ^ w[CHECK_POS[g][s][1]] ^
                  w[CHECK_POS[g][s][2]] ^ w[CHECK_POS[g][s][3]];
      end
      groups[g] = vote_of_six(sums);
    end
    f = w;
    f[TOP_POS] = w[TOP_POS] ^ vote_of_six(groups);
    return {f[TOP_POS-1:0], f[TOP_POS]};
  endfunction

endpackage

[rtl/core/msmd_if.sv]
// ---------------------------------------------------------------------------
// msmd channel interfaces
// Valid/ready channels for received words and corrected words.
// ---------------------------------------------------------------------------
interface msmd_in_if
  import msmd_pkg::*;
  ();
  logic  valid;
  logic  ready;
  word_t received_word;

  modport source (output valid, output received_word, input ready);
  modport sink   (input valid, input received_word, output ready);
endinterface

interface msmd_out_if
  import msmd_pkg::*;
  ();
  logic  valid;
  logic  ready;
  word_t corrected_word;

  modport source (output valid, output corrected_word, input ready);
  modport sink   (input valid, input corrected_word, output ready);
endinterface

[rtl/core/msmd_round.sv]
// ---------------------------------------------------------------------------
// msmd_round
// One pipeline stage: a single majority-logic round into a valid register.
// ---------------------------------------------------------------------------
module msmd_round
  import msmd_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  up_valid,
  output logic  up_ready,
  input  word_t up_word,
  output logic  dn_valid,
  input  logic  dn_ready,
  output word_t dn_word
);

  logic  valid;
  word_t word;

  // stage takes a new word when empty or when its word moves on
  assign up_ready = !valid || dn_ready;

  // stage valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  // round result
  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      word <= decode_round(up_word);
    end
  end

  assign dn_valid = valid;
  assign dn_word  = word;

endmodule

[rtl/core/multi_step_majority_decoder_15_5.sv]
// ---------------------------------------------------------------------------
// multi_step_majority_decoder_15_5
// Multi-step majority-logic decoder for the (15,5) cyclic code.
// ---------------------------------------------------------------------------
// A received 15-bit word (bit i is code position i) goes through fifteen
// pipeline stages, one per decoding round; each stage forms 36 four-bit
// check sums, votes in six groups and again over the groups, corrects
// position 14 and rotates the word by one. A word is accepted every cycle
// while the output is not stalled; its corrected word leaves on the output
// channel, whose register is the last round stage. Each stage holds its
// word while the stage after it cannot take it, so a stalled output loses
// nothing, and empty stages close up so input keeps flowing until all
// fifteen stages hold words. There is no error flag: an uncorrectable word
// leaves as the rounds leave it.
`include "multi_step_majority_decoder_15_5_assert.svh"

module multi_step_majority_decoder_15_5
  import msmd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  msmd_in_if.sink           din,
  msmd_out_if.source        dout
);

  logic [NUM_ROUNDS:0] stage_valid;
  logic [NUM_ROUNDS:0] stage_ready;
  word_t               stage_word [NUM_ROUNDS+1];

  // input channel feeds the head of the pipeline
  assign stage_valid[0] = din.valid;
  assign stage_word[0]  = din.received_word;
  assign din.ready      = stage_ready[0];

  // one stage per round
  for (genvar k = 0; k < NUM_ROUNDS; k++) begin : g_round
    msmd_round u_round (
      .clk      (clk),
      .rst      (rst),
      .up_valid (stage_valid[k]),
      .up_ready (stage_ready[k]),
      .up_word  (stage_word[k]),
      .dn_valid (stage_valid[k+1]),
      .dn_ready (stage_ready[k+1]),
      .dn_word  (stage_word[k+1])
    );
  end

  // last stage drives the output channel
  assign stage_ready[NUM_ROUNDS] = dout.ready;
  assign dout.valid              = stage_valid[NUM_ROUNDS];
  assign dout.corrected_word     = stage_word[NUM_ROUNDS];

  // checks
  `MSMD_ASSERT(a_ready_when_out_empty, clk, rst, !dout.valid |-> din.ready)
  `MSMD_ASSERT(a_drain_empties_out, clk, rst, (dout.valid && dout.ready && !stage_valid[NUM_ROUNDS-1]) |=> !dout.valid)
  `MSMD_ASSERT(a_stall_keeps_full, clk, rst, (stage_valid[1] && !stage_ready[1]) |=> stage_valid[1])
  `MSMD_ASSERT_RESET(a_reset_empties, clk, rst, !dout.valid && (stage_valid[NUM_ROUNDS:1] == '0))

endmodule

[test/msmd_decoder_monitor.sv]
// ---------------------------------------------------------------------------
// msmd_decoder_monitor
// Watches both channels of the (15,5) majority-logic decoder, works out the
// corrected word of every accepted received word and compares it, in order,
// with each corrected word that leaves the block.
// ---------------------------------------------------------------------------
module msmd_decoder_monitor
  import msmd_pkg::word_t;
(
  input  logic clk,
  input  logic rst,
  msmd_in_if   din,
  msmd_out_if  dout,
  output int   errors,
  output int   pending,
  output int   words
);

  localparam int ROUNDS = 15;
  localparam int GROUPS = 6;
  localparam int SUMS   = 6;

  // four-position check sums as masks, six groups of six
  localparam word_t SUM_MASK [GROUPS*SUMS] = '{
    15'h6410, 15'h7080, 15'h6A00, 15'h6101, 15'h6022, 15'h6048,
    15'h5401, 15'h5808, 15'h7080, 15'h5006, 15'h5110, 15'h5240,
    15'h5808, 15'h6A00, 15'h4821, 15'h4902, 15'h4814, 15'h48C0,
    15'h5401, 15'h6410, 15'h4442, 15'h4428, 15'h4580, 15'h4604,
    15'h4821, 15'h6022, 15'h4428, 15'h4070, 15'h40A4, 15'h4320,
    15'h5006, 15'h4814, 15'h4045, 15'h410C, 15'h40A4, 15'h4604
  };

  word_t corrected_due [$];

  // fifteen rounds: vote per group, vote over groups, fix bit 14, rotate up
  function automatic word_t majority_corrected(word_t w);
    int r;
    int g;
    int s;
    int ones;
    int group_votes;
    for (r = 0; r < ROUNDS; r++) begin
      group_votes = 0;
      for (g = 0; g < GROUPS; g++) begin
        ones = 0;
        for (s = 0; s < SUMS; s++) begin
          ones += int'(^(w & SUM_MASK[g*SUMS+s]));
        end
        if (ones > 3) group_votes++;
      end
      if (group_votes > 3) w[14] = ~w[14];
      w = {w[13:0], w[14]};
    end
    return w;
  endfunction

  initial begin
    errors  = 0;
    pending = 0;
    words   = 0;
  end

  // predict on input transactions, compare on output transactions
  always @(posedge clk) begin
    if (!rst) begin
      if (din.valid && din.ready) begin
        corrected_due.push_back(majority_corrected(din.received_word));
      end
      if (dout.valid && dout.ready) begin
        words++;
        if (corrected_due.size() == 0) begin
          errors++;
          $error("corrected_word %h arrived with no transaction outstanding",
                 dout.corrected_word);
        end else if (dout.corrected_word !== corrected_due[0]) begin
          errors++;
          $error("corrected_word mismatch: expected %h, actual %h",
                 corrected_due[0], dout.corrected_word);
          void'(corrected_due.pop_front());
        end else begin
          void'(corrected_due.pop_front());
        end
      end
      pending = corrected_due.size();
    end
  end

endmodule

[test/tb_multi_step_majority_decoder_15_5.sv]
// ---------------------------------------------------------------------------
// tb_multi_step_majority_decoder_15_5
// Drives received words into the decoder and stalls its output, under three
// mixes of idling and one long output stall; the monitor checks each result.
// ---------------------------------------------------------------------------
module tb_multi_step_majority_decoder_15_5;
  import msmd_pkg::word_t;

  localparam int    QUIET_LIMIT  = 2000;
  localparam int    STALL_CYCLES = 60;
  localparam int    DRAIN_CYCLES = 30;
  localparam int    PHASE_WORDS  = 300;
  localparam word_t GEN_POLY     = 15'h0537;

  logic clk;
  logic rst;
  int   send_idle_pct;
  int   recv_idle_pct;
  bit   stall_req;
  int   quiet;
  int   errors;
  int   pending;
  int   words;
  int   directed;

  msmd_in_if  din_ch ();
  msmd_out_if dout_ch ();

  multi_step_majority_decoder_15_5 dut (
    .clk  (clk),
    .rst  (rst),
    .din  (din_ch),
    .dout (dout_ch)
  );

  msmd_decoder_monitor monitor (
    .clk     (clk),
    .rst     (rst),
    .din     (din_ch),
    .dout    (dout_ch),
    .errors  (errors),
    .pending (pending),
    .words   (words)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // codeword of the cyclic code for a five-bit message
  function automatic word_t code_word(logic [4:0] msg);
    word_t cw;
    cw = '0;
    for (int i = 0; i < 5; i++) begin
      if (msg[i]) cw ^= GEN_POLY << i;
    end
    return cw;
  endfunction

  // flip n randomly chosen positions, which may repeat
  function automatic word_t flip_bits(word_t w, int n);
    int pos;
    for (int k = 0; k < n; k++) begin
      pos    = $urandom_range(14);
      w[pos] = ~w[pos];
    end
    return w;
  endfunction

  // offer one word, with random idle cycles before it
  task automatic send_word(input word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      din_ch.valid <= 1'b0;
      @(posedge clk);
    end
    din_ch.valid         <= 1'b1;
    din_ch.received_word <= w;
    do @(posedge clk); while (!din_ch.ready);
  endtask

  // mostly corrupted codewords, some beyond the correction range, some noise
  task automatic send_random(input int count);
    int    pick;
    word_t w;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        w = flip_bits(code_word(5'($urandom_range(31))), $urandom_range(3));
      end else if (pick < 90) begin
        w = flip_bits(code_word(5'($urandom_range(31))), $urandom_range(5, 4));
      end else begin
        w = word_t'($urandom_range(32767));
      end
      send_word(w);
    end
  endtask

  // output side: random back-pressure, or a long hold when asked
  initial begin
    dout_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_req) begin
        dout_ch.ready <= 1'b0;
        repeat (STALL_CYCLES - 1) @(posedge clk);
        stall_req = 1'b0;
      end else begin
        dout_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst) begin
      quiet <= 0;
    end else if ((din_ch.valid && din_ch.ready) || (dout_ch.valid && dout_ch.ready)) begin
      quiet <= 0;
    end else if (quiet == QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // stimulus and verdict
  initial begin
    word_t edge_words [$];
    rst                  <= 1'b1;
    din_ch.valid         <= 1'b0;
    din_ch.received_word <= '0;
    send_idle_pct = 14;
    recv_idle_pct = 76;
    stall_req     = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: all zeros, all ones, single errors, checkerboards, codewords
    edge_words.push_back(15'h0000);
    edge_words.push_back(15'h7FFF);
    for (int i = 0; i < 15; i++) edge_words.push_back(word_t'(1) << i);
    edge_words.push_back(15'h5555);
    edge_words.push_back(15'h2AAA);
    edge_words.push_back(code_word(5'h1F));
    edge_words.push_back(code_word(5'h1F) ^ 15'h7000);
    edge_words.push_back(code_word(5'h01) ^ 15'h000F);
    edge_words.push_back(code_word(5'h10) ^ 15'h4001);
    directed = edge_words.size();
    foreach (edge_words[i]) send_word(edge_words[i]);

    send_random(PHASE_WORDS);

    send_idle_pct = 76;
    recv_idle_pct = 14;
    send_random(PHASE_WORDS);

    // no idling; open with a long output hold so the pipeline backs up
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_req     = 1'b1;
    send_random(PHASE_WORDS);
    din_ch.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d words (%0d directed), codewords with up to five flipped",
             words, directed);
    $display("positions plus noise, three idle mixes and a %0d-cycle output hold",
             STALL_CYCLES);
    if (errors == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
